@@ design/hex_register_frame_encoder_assert.svh @@
// Assertion macros for the hex register frame encoder.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef HEX_REGISTER_FRAME_ENCODER_ASSERT_SVH
`define HEX_REGISTER_FRAME_ENCODER_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define HRFE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hrfe assertion failed");
// next-cycle implication
`define HRFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hrfe assertion failed");
`else
`define HRFE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HRFE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ design/hrfe_pkg.sv @@
// Shared types, constants and helpers for the hex register frame encoder.
// No dependencies.
`timescale 1ns / 1ps

package hrfe_pkg;

    localparam int unsigned InWidth  = 56;  // 54 bits of fields, padded to bytes
    localparam int unsigned OutWidth = 8;
    localparam int unsigned PayBits  = 56;  // reg id, flags byte, 32-bit value
    localparam int unsigned CntWidth = 4;

    localparam logic [7:0] CKSUM_SEED = 8'h55;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;

    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_GET   = 2'd1;
    localparam logic [1:0] KIND_SET16 = 2'd2;
    localparam logic [1:0] KIND_SET32 = 2'd3;

    typedef struct packed {
        logic load;   // take a new frame description
        logic step;   // one payload digit has gone out
    } t_dp_ctrl;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] w;
        w = {4'b0000, nib};
        if (nib < 4'd10) begin
            return CH_ZERO + w;
        end else begin
            return CH_UPPER_A + w - 8'd10;
        end
    endfunction

    // payload hex digits for each frame kind
    function automatic logic [CntWidth-1:0] digit_count(input logic [1:0] kind);
        logic [CntWidth-1:0] n;
        unique case (kind)
            KIND_CMD:   n = 4'd0;
            KIND_GET:   n = 4'd6;
            KIND_SET16: n = 4'd10;
            KIND_SET32: n = 4'd14;
            default:    n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

@@ design/hex_register_frame_encoder.sv @@
// Top level of the hex register frame encoder: frame sequencer and output register.
// Depends on hrfe_pkg, hrfe_datapath and hex_register_frame_encoder_assert.svh.
`timescale 1ns / 1ps
`include "hex_register_frame_encoder_assert.svh"

// Turns one frame description per input transaction into an ASCII hex frame:
// ':' , the command nibble as one digit, for kinds 1..3 the payload bytes (register id low
// byte first, a zero flags byte, then 16 or 32 bits of value for kinds 2 and 3, low byte first)
// as two uppercase digits each, the checksum 0x55 minus command and payload
// bytes, and a closing newline flagged with m_tlast. One character leaves per
// output transaction. Frames are 5, 11, 15 or 19 characters for kinds 0..3.
// The payload goes through a byte shift register one hex digit per cycle while
// the output register can take a character, with an 8-bit running checksum;
// the next item is taken on the cycle after the newline is loaded.
// s_tready is high only while the sequencer is idle; the output register lets
// the newline wait for m_tready while the next item is accepted.

module hex_register_frame_encoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [1:0] cmd, [5:2] command_code, [21:6] register_id, [53:22] reg_value,
    // [55:54] zero
    input  logic [hrfe_pkg::InWidth-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] char_out
    output logic [hrfe_pkg::OutWidth-1:0]  m_tdata,
    output logic                           m_tlast   // last_char
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COLON,
        S_CODE,
        S_PAYLOAD,
        S_SUM_HI,
        S_SUM_LO,
        S_NL
    } t_state;

    t_state                          r_state;
    logic [hrfe_pkg::CntWidth-1:0]   r_cnt;     // payload digits still to send
    logic [3:0]                      r_code;
    logic                            r_tvalid;
    logic [7:0]                      r_tdata;
    logic                            r_tlast;

    logic                            w_adv;     // output register may take a char
    logic                            w_accept;
    hrfe_pkg::t_dp_ctrl              w_ctrl;
    logic [3:0]                      w_nibble;
    logic [7:0]                      w_sum;

    assign w_adv    = ~r_tvalid | m_tready;
    assign s_tready = i_rst_n & (r_state == S_IDLE);
    assign w_accept = s_tvalid & s_tready;

    assign w_ctrl.load = w_accept;
    assign w_ctrl.step = w_adv & (r_state == S_PAYLOAD);

    assign m_tvalid = r_tvalid;
    assign m_tdata  = r_tdata;
    assign m_tlast  = r_tlast;

    hrfe_datapath u_datapath (
        .i_clk         (i_clk),
        .i_ctrl        (w_ctrl),
        .i_code        (s_tdata[5:2]),
        .i_register_id (s_tdata[21:6]),
        .i_reg_value   (s_tdata[53:22]),
        .o_nibble      (w_nibble),
        .o_sum         (w_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_tvalid <= 1'b0;
            r_tlast  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_code <= s_tdata[5:2];
                r_cnt  <= hrfe_pkg::digit_count(s_tdata[1:0]);
            end
            if (w_adv) begin
                // only the newline is marked
                r_tlast <= (r_state == S_NL);
                unique case (r_state)
                    S_IDLE: begin
                        r_tvalid <= 1'b0;
                    end
                    S_COLON: begin
                        r_tvalid <= 1'b1;
                        r_tdata  <= hrfe_pkg::CH_COLON;
                    end
                    S_CODE: begin
                        r_tvalid <= 1'b1;
                        r_tdata  <= hrfe_pkg::hex_char(r_code);
                    end
                    S_PAYLOAD: begin
                        r_tvalid <= 1'b1;
                        r_tdata  <= hrfe_pkg::hex_char(w_nibble);
                        r_cnt    <= r_cnt - 1'b1;
                    end
                    S_SUM_HI: begin
                        r_tvalid <= 1'b1;
                        r_tdata  <= hrfe_pkg::hex_char(w_sum[7:4]);
                    end
                    S_SUM_LO: begin
                        r_tvalid <= 1'b1;
                        r_tdata  <= hrfe_pkg::hex_char(w_sum[3:0]);
                    end
                    S_NL: begin
                        r_tvalid <= 1'b1;
                        r_tdata  <= hrfe_pkg::CH_NL;
                    end
                    default: begin
                        r_tvalid <= 1'b0;
                    end
                endcase
            end
            // sequencer
            unique case (r_state)
                S_IDLE:    if (w_accept) r_state <= S_COLON;
                S_COLON:   if (w_adv) r_state <= S_CODE;
                S_CODE:    if (w_adv) r_state <= (r_cnt == '0) ? S_SUM_HI : S_PAYLOAD;
                S_PAYLOAD: if (w_adv && r_cnt == 4'd1) r_state <= S_SUM_HI;
                S_SUM_HI:  if (w_adv) r_state <= S_SUM_LO;
                S_SUM_LO:  if (w_adv) r_state <= S_NL;
                S_NL:      if (w_adv) r_state <= S_IDLE;
                default:   r_state <= S_IDLE;
            endcase
        end
    end

    // a new frame always opens with the start character
    `HRFE_ASSERT_NEXT(a_accept_to_colon, i_clk, i_rst_n, w_accept, r_state == S_COLON)
    // the marked character is always the newline
    `HRFE_ASSERT_IMPL(a_last_is_nl, i_clk, i_rst_n, r_tvalid && r_tlast, r_tdata == hrfe_pkg::CH_NL)
    // payload state never runs with an empty digit count
    `HRFE_ASSERT_IMPL(a_payload_cnt, i_clk, i_rst_n, r_state == S_PAYLOAD, r_cnt != '0)
    // newline loaded into the output register ends the frame
    `HRFE_ASSERT_NEXT(a_nl_to_idle, i_clk, i_rst_n, r_state == S_NL && w_adv, r_state == S_IDLE && r_tlast)

endmodule

@@ design/hrfe_datapath.sv @@
// Payload shift register and running checksum, one hex digit per step.
// Depends on hrfe_pkg.
`timescale 1ns / 1ps

module hrfe_datapath (
    input  logic                       i_clk,
    input  hrfe_pkg::t_dp_ctrl         i_ctrl,
    input  logic [3:0]                 i_code,
    input  logic [15:0]                i_register_id,
    input  logic [31:0]                i_reg_value,
    output logic [3:0]                 o_nibble,
    output logic [7:0]                 o_sum
);

    logic [hrfe_pkg::PayBits-1:0] r_shift, n_shift;
    logic                         r_low, n_low;   // 0: high digit of byte next
    logic [7:0]                   r_sum, n_sum;

    // high digit of the current byte first, then the low digit
    assign o_nibble = r_low ? r_shift[3:0] : r_shift[7:4];
    assign o_sum    = r_sum;

    always_comb begin
        n_shift = r_shift;
        n_low   = r_low;
        n_sum   = r_sum;
        if (i_ctrl.load) begin
            n_shift = {i_reg_value, 8'h00, i_register_id};
            n_low   = 1'b0;
            n_sum   = hrfe_pkg::CKSUM_SEED - {4'b0000, i_code};
        end else if (i_ctrl.step) begin
            if (r_low) begin
                n_sum   = r_sum - {4'b0000, o_nibble};
                n_shift = {8'h00, r_shift[hrfe_pkg::PayBits-1:8]};
            end else begin
                n_sum   = r_sum - {o_nibble, 4'b0000};
            end
            n_low = ~r_low;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_low   <= n_low;
        r_sum   <= n_sum;
    end

endmodule
